// File: src/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg: door motion controller shared types and constants
// Door states, item codes, payload structs and the timing constants.
// ----------------------------------------------------------------------------
package dmc_pkg;

   // door states
   typedef enum logic [2:0] {
      ST_UNKNOWN = 3'd0,
      ST_CLOSED  = 3'd1,
      ST_OPENING = 3'd2,
      ST_OPEN    = 3'd3,
      ST_CLOSING = 3'd4,
      ST_STOPPED = 3'd5
   } state_type;

   // item opcodes
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_OPEN  = 3'd1;
   localparam logic [2:0] OP_CLOSE = 3'd2;
   localparam logic [2:0] OP_STOP  = 3'd3;
   localparam logic [2:0] OP_POS   = 3'd4;

   // sensed positions
   localparam logic [1:0] POS_OPEN   = 2'd1;
   localparam logic [1:0] POS_CLOSED = 2'd2;

   // command status
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_INVALID = 2'd1;
   localparam logic [1:0] STS_RELAY   = 2'd2;

   // event codes
   localparam logic [2:0] EV_NONE        = 3'd0;
   localparam logic [2:0] EV_TIMEOUT     = 3'd1;
   localparam logic [2:0] EV_OBSTRUCTION = 3'd2;
   localparam logic [2:0] EV_OPEN_START  = 3'd3;
   localparam logic [2:0] EV_CLOSE_START = 3'd4;

   // timing
   localparam int unsigned TIMEOUT_W = 20;
   localparam int unsigned DIV_W     = 7;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd30000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_MIN   = 20'd1000;
   localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = '1;
   localparam logic [DIV_W-1:0]     SAFETY_INTERVAL_TICKS = 7'd100;

   // one input item
   typedef struct packed {
      logic [2:0] opcode;
      logic [1:0] position;
      logic       relay_ok;
   } req_type;

   // one result item
   typedef struct packed {
      logic [2:0] door_state;
      logic       state_changed;
      logic [1:0] status;
      logic [2:0] event_code;
      logic       relay_pulse;
   } rsp_type;

endpackage

// File: src/dmc_if.sv
// ----------------------------------------------------------------------------
// dmc channel interfaces
// Valid/ready channels for request items, result items and register writes.
// ----------------------------------------------------------------------------
interface dmc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [1:0] position;
   logic       relay_ok;

   modport source (output valid, output opcode, output position, output relay_ok,
                   input ready);
   modport sink (input valid, input opcode, input position, input relay_ok,
                 output ready);
endinterface

interface dmc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] door_state;
   logic       state_changed;
   logic [1:0] status;
   logic [2:0] event_code;
   logic       relay_pulse;

   modport source (output valid, output door_state, output state_changed,
                   output status, output event_code, output relay_pulse,
                   input ready);
   modport sink (input valid, input door_state, input state_changed,
                 input status, input event_code, input relay_pulse,
                 output ready);
endinterface

interface dmc_csr_if;
   logic        valid;
   logic        ready;
   logic [19:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: src/dmc_fsm.sv
// ----------------------------------------------------------------------------
// dmc_fsm: door motion state and per-item transition logic
// Holds the door state, move timer and safety divider; computes one result
// per item from the registered item and updates state when it advances.
// ----------------------------------------------------------------------------
module dmc_fsm import dmc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  req_type              item,
   input  logic [TIMEOUT_W-1:0] move_timeout,
   output rsp_type              result
);

   state_type            state_ff, state_in;
   logic [TIMEOUT_W-1:0] elapsed_ff, elapsed_in;
   logic [DIV_W-1:0]     divider_ff, divider_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_UNKNOWN;
         elapsed_ff <= '0;
         divider_ff <= '0;
      end else if (advance) begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
         divider_ff <= divider_in;
      end
   end

   // transition logic
   always_comb begin
      state_type            st;
      logic [TIMEOUT_W-1:0] el;
      logic [DIV_W-1:0]     dv;
      logic                 chg;
      logic [1:0]           sts;
      logic [2:0]           ev;
      logic                 pulse;
      logic                 moving;
      logic                 can_open;
      logic                 can_close;

      st        = state_ff;
      el        = elapsed_ff;
      dv        = divider_ff;
      chg       = 1'b0;
      sts       = STS_OK;
      ev        = EV_NONE;
      pulse     = 1'b0;
      moving    = (state_ff == ST_OPENING) || (state_ff == ST_CLOSING);
      can_open  = (state_ff == ST_CLOSED) || (state_ff == ST_STOPPED);
      can_close = (state_ff == ST_OPEN) || (state_ff == ST_STOPPED);

      unique case (item.opcode)
         OP_TICK: begin
            // move timeout, counted only while moving
            if (moving) begin
               if (el != ELAPSED_MAX) begin
                  el = el + 1'b1;
               end
               if (el >= move_timeout) begin
                  st = ST_STOPPED;
                  el = '0;
                  ev = EV_TIMEOUT;
               end
            end
            // periodic safety check on the state left by the timeout
            dv = dv + 1'b1;
            if (dv >= SAFETY_INTERVAL_TICKS) begin
               dv = '0;
               if (st == ST_OPENING) begin
                  if (item.position == POS_CLOSED) begin
                     st = ST_STOPPED;
                     el = '0;
                     ev = EV_OBSTRUCTION;
                  end else if (item.position == POS_OPEN) begin
                     st = ST_OPEN;
                     el = '0;
                  end
               end else if (st == ST_CLOSING) begin
                  if (item.position == POS_OPEN) begin
                     st = ST_STOPPED;
                     el = '0;
                     ev = EV_OBSTRUCTION;
                  end else if (item.position == POS_CLOSED) begin
                     st = ST_CLOSED;
                     el = '0;
                  end
               end
            end
         end
         OP_OPEN: begin
            if (!can_open) begin
               sts = STS_INVALID;
            end else if (!item.relay_ok) begin
               sts = STS_RELAY;
            end else begin
               st    = ST_OPENING;
               el    = '0;
               ev    = EV_OPEN_START;
               pulse = 1'b1;
            end
         end
         OP_CLOSE: begin
            if (!can_close) begin
               sts = STS_INVALID;
            end else if (!item.relay_ok) begin
               sts = STS_RELAY;
            end else begin
               st    = ST_CLOSING;
               el    = '0;
               ev    = EV_CLOSE_START;
               pulse = 1'b1;
            end
         end
         OP_STOP: begin
            if ((state_ff != ST_OPEN) && (state_ff != ST_CLOSED)) begin
               st = ST_STOPPED;
               el = '0;
            end
         end
         OP_POS: begin
            if (moving) begin
               if (item.position == POS_OPEN) begin
                  st = ST_OPEN;
                  el = '0;
               end else if (item.position == POS_CLOSED) begin
                  st = ST_CLOSED;
                  el = '0;
               end
            end
         end
         default: begin
            // unused opcodes leave everything as is
         end
      endcase

      chg = (st != state_ff);

      state_in             = st;
      elapsed_in           = el;
      divider_in           = dv;
      result.door_state    = 3'(st);
      result.state_changed = chg;
      result.status        = sts;
      result.event_code    = ev;
      result.relay_pulse   = pulse;
   end

endmodule

// File: src/door_motion_controller.sv
// ----------------------------------------------------------------------------
// door_motion_controller: door motion state machine top level
// Input register, transition logic and result register with valid/ready
// channels, plus the timeout configuration register.
// ----------------------------------------------------------------------------
// path: an accepted item is held in the input register and its result in the result
//   register until taken; a stall on the result channel holds both registers
// throughput: one item per cycle while results are taken; the door state in dmc_fsm
//   is updated as each item advances
// reset: door state unknown, move timer and safety divider zero, timeout 30000,
//   both pipeline registers empty
module door_motion_controller import dmc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   dmc_req_if.sink  req_ch,
   dmc_rsp_if.source rsp_ch,
   dmc_csr_if.sink  csr_ch
);

   logic                 in_valid_ff;
   req_type              in_item_ff;
   logic                 out_valid_ff;
   rsp_type              out_item_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic                 advance;
   rsp_type              result;

   // pipeline control
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff.opcode   <= req_ch.opcode;
         in_item_ff.position <= req_ch.position;
         in_item_ff.relay_ok <= req_ch.relay_ok;
      end
   end

   // timeout register, short values ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_ch.valid && csr_ch.ready && (csr_ch.data >= TIMEOUT_MIN)) begin
         timeout_ff <= csr_ch.data;
      end
   end

   // transition logic and door state
   dmc_fsm u_fsm (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (in_item_ff),
      .move_timeout (timeout_ff),
      .result       (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.door_state    = out_item_ff.door_state;
   assign rsp_ch.state_changed = out_item_ff.state_changed;
   assign rsp_ch.status        = out_item_ff.status;
   assign rsp_ch.event_code    = out_item_ff.event_code;
   assign rsp_ch.relay_pulse   = out_item_ff.relay_pulse;

endmodule

// File: tb/sv/door_motion_controller_tb.sv
// ----------------------------------------------------------------------------
// door_motion_controller_tb: self-checking testbench for the door controller
// Feeds command, tick and position items through the request channel, predicts
// every result with a cycle-free model of the door state machine and compares
// each result field by field, under random gaps and stalls and several timeout settings.
// ----------------------------------------------------------------------------
module door_motion_controller_tb;
   import dmc_pkg::*;

   // codes with no name in the package
   localparam logic [2:0] OP_BAD_FIRST = 3'd5;
   localparam logic [2:0] OP_BAD_LAST  = 3'd7;
   localparam logic [1:0] POS_BETWEEN  = 2'd0;
   localparam logic [1:0] POS_BOGUS    = 2'd3;

   localparam int CYCLE_LIMIT    = 1000000;
   localparam int DRAIN_CYCLES   = 6;
   localparam int PHASE_ITEMS    = 8;
   localparam int TIMEOUT_PHASE  = 2;
   localparam int PRESSURE_AFTER = 300;
   localparam int PRESSURE_HOLD  = 150;
   localparam int NUM_PHASES     = 7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dmc_req_if req_ch ();
   dmc_rsp_if rsp_ch ();
   dmc_csr_if csr_ch ();

   door_motion_controller u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // stimulus and expectation stores
   req_type pending_items[$];
   rsp_type door_results_due[$];

   // predicted door state and configuration
   state_type              door_now;
   logic [TIMEOUT_W-1:0]   move_ms;
   logic [DIV_W-1:0]       tick_div;
   logic [TIMEOUT_W-1:0]   move_limit;

   int      mismatch_count = 0;
   int      results_seen   = 0;
   int      cycle_count    = 0;
   int      ticks_queued   = 0;
   int      phase_items    = 0;
   logic    req_taken      = 1'b0;
   int      req_gap        = 0;
   int      req_steady     = 0;
   int      rsp_hold       = 0;
   int      rsp_calm       = 0;
   bit      pressure_done  = 1'b0;
   req_type next_req;

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic in_motion(state_type s);
      return (s == ST_OPENING) || (s == ST_CLOSING);
   endfunction

   // moves the predicted door to a state, returns 1 when the state changed
   function automatic logic enter_state(state_type s);
      logic changed;
      changed = (door_now != s);
      door_now = s;
      if (!in_motion(s)) begin
         move_ms = '0;
      end
      return changed;
   endfunction

   // expected result of one request item, updates the predicted state
   function automatic rsp_type advance_door(req_type item);
      rsp_type r;
      r = '0;
      case (item.opcode)
         OP_TICK: begin
            if (in_motion(door_now)) begin
               if (move_ms != ELAPSED_MAX) begin
                  move_ms = move_ms + 1'b1;
               end
               if (move_ms >= move_limit) begin
                  r.state_changed = r.state_changed | enter_state(ST_STOPPED);
                  r.event_code = EV_TIMEOUT;
               end
            end
            tick_div = tick_div + 1'b1;
            // periodic safety check on the sensed position
            if (tick_div >= SAFETY_INTERVAL_TICKS) begin
               tick_div = '0;
               if (door_now == ST_OPENING) begin
                  if (item.position == POS_CLOSED) begin
                     r.state_changed = r.state_changed | enter_state(ST_STOPPED);
                     r.event_code = EV_OBSTRUCTION;
                  end else if (item.position == POS_OPEN) begin
                     r.state_changed = r.state_changed | enter_state(ST_OPEN);
                  end
               end else if (door_now == ST_CLOSING) begin
                  if (item.position == POS_OPEN) begin
                     r.state_changed = r.state_changed | enter_state(ST_STOPPED);
                     r.event_code = EV_OBSTRUCTION;
                  end else if (item.position == POS_CLOSED) begin
                     r.state_changed = r.state_changed | enter_state(ST_CLOSED);
                  end
               end
            end
         end
         OP_OPEN: begin
            if (door_now != ST_CLOSED && door_now != ST_STOPPED) begin
               r.status = STS_INVALID;
            end else if (!item.relay_ok) begin
               r.status = STS_RELAY;
            end else begin
               r.relay_pulse = 1'b1;
               r.state_changed = enter_state(ST_OPENING);
               move_ms = '0;
               r.event_code = EV_OPEN_START;
            end
         end
         OP_CLOSE: begin
            if (door_now != ST_OPEN && door_now != ST_STOPPED) begin
               r.status = STS_INVALID;
            end else if (!item.relay_ok) begin
               r.status = STS_RELAY;
            end else begin
               r.relay_pulse = 1'b1;
               r.state_changed = enter_state(ST_CLOSING);
               move_ms = '0;
               r.event_code = EV_CLOSE_START;
            end
         end
         OP_STOP: begin
            if (door_now != ST_OPEN && door_now != ST_CLOSED) begin
               r.state_changed = enter_state(ST_STOPPED);
            end
         end
         OP_POS: begin
            if (in_motion(door_now)) begin
               if (item.position == POS_OPEN) begin
                  r.state_changed = enter_state(ST_OPEN);
               end else if (item.position == POS_CLOSED) begin
                  r.state_changed = enter_state(ST_CLOSED);
               end
            end
         end
         default: begin
         end
      endcase
      r.door_state = door_now;
      return r;
   endfunction

   task automatic check_field(input string field, input int due, input int seen);
      if (due != seen) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, due, seen);
      end
   endtask

   // monitor: prediction on accepted items, checking of accepted results
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("door_motion_controller_tb: FAIL");
         $finish;
      end
      if (reset) begin
         door_now   = ST_UNKNOWN;
         move_ms    = '0;
         tick_div   = '0;
         move_limit = TIMEOUT_RESET;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            door_results_due.push_back(advance_door(
               '{opcode: req_ch.opcode, position: req_ch.position,
                 relay_ok: req_ch.relay_ok}));
         end
         // values below the minimum leave the timeout as it was
         if (csr_ch.valid && csr_ch.ready && csr_ch.data >= TIMEOUT_MIN) begin
            move_limit = csr_ch.data;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (door_results_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no item outstanding, actual state %0d", $time,
                        rsp_ch.door_state);
            end else begin
               rsp_type due;
               due = door_results_due.pop_front();
               check_field("door_state", due.door_state, rsp_ch.door_state);
               check_field("state_changed", due.state_changed, rsp_ch.state_changed);
               check_field("status", due.status, rsp_ch.status);
               check_field("event_code", due.event_code, rsp_ch.event_code);
               check_field("relay_pulse", due.relay_pulse, rsp_ch.relay_pulse);
            end
         end
      end
   end

   // request driver with random gaps and gap-free stretches
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            next_req = pending_items.pop_front();
            req_ch.valid    <= 1'b1;
            req_ch.opcode   <= next_req.opcode;
            req_ch.position <= next_req.position;
            req_ch.relay_ok <= next_req.relay_ok;
            if (req_steady > 0) begin
               req_steady = req_steady - 1;
            end else if ($urandom_range(0, 99) < 5) begin
               req_steady = $urandom_range(20, 80);
            end else if ($urandom_range(0, 99) < 55) begin
               req_gap = 0;
            end else if ($urandom_range(0, 99) < 80) begin
               req_gap = $urandom_range(1, 3);
            end else begin
               req_gap = $urandom_range(8, 30);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls, calm stretches and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
         pressure_done = 1'b1;
         rsp_hold = PRESSURE_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_calm > 0) begin
         rsp_calm = rsp_calm - 1;
         rsp_ch.ready <= 1'b1;
      end else begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            rsp_calm = $urandom_range(20, 60);
            rsp_ch.ready <= 1'b1;
         end else if (pick < 70) begin
            rsp_ch.ready <= 1'b1;
         end else if (pick < 95) begin
            rsp_hold = $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_hold = $urandom_range(10, 40);
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   task automatic queue_item(input logic [2:0] op, input logic [1:0] pos, input logic relay);
      req_type it;
      it.opcode   = op;
      it.position = pos;
      it.relay_ok = relay;
      pending_items.push_back(it);
      if (op == OP_TICK) begin
         ticks_queued++;
      end
      phase_items++;
   endtask

   // mostly well-formed moves with tick runs, some noise and loose ticks
   task automatic queue_random_traffic(input int count);
      int pick;
      int run;
      logic [1:0] hold_pos;
      bit mixed;
      while (phase_items < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            queue_item(OP_STOP, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            queue_item($urandom_range(0, 1) ? OP_OPEN : OP_CLOSE, 2'($urandom_range(0, 3)),
                       $urandom_range(0, 9) != 0);
            run = ($urandom_range(0, 9) < 7) ? $urandom_range(60, 140) : $urandom_range(1, 40);
            hold_pos = 2'($urandom_range(0, 3));
            mixed = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < run; k++) begin
               queue_item(OP_TICK, mixed ? 2'($urandom_range(0, 3)) : hold_pos,
                          1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 1)) begin
               queue_item(OP_POS, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end
         end else if (pick < 80) begin
            run = $urandom_range(1, 4);
            for (int k = 0; k < run; k++) begin
               queue_item(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)));
            end
         end else begin
            run = $urandom_range(1, 30);
            for (int k = 0; k < run; k++) begin
               queue_item(OP_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   // a move that times out on the very tick the safety check runs, with the
   // door sensed at the far end; the timeout must win
   task automatic queue_timeout_on_check();
      while (ticks_queued % SAFETY_INTERVAL_TICKS != 0) begin
         queue_item(OP_TICK, $urandom_range(0, 1) ? POS_BETWEEN : POS_BOGUS, 1'b0);
      end
      queue_item(OP_STOP, POS_BETWEEN, 1'b1);
      queue_item(OP_CLOSE, POS_BETWEEN, 1'b1);
      queue_item(OP_STOP, POS_BETWEEN, 1'b1);
      queue_item(OP_OPEN, POS_BETWEEN, 1'b1);
      for (int k = 1; k < TIMEOUT_MIN; k++) begin
         queue_item(OP_TICK, $urandom_range(0, 1) ? POS_BETWEEN : POS_BOGUS,
                    1'($urandom_range(0, 1)));
      end
      queue_item(OP_TICK, POS_OPEN, 1'b1);
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_items.size() != 0 || req_ch.valid || door_results_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do begin
         @(posedge clock);
      end while (!(csr_ch.valid && csr_ch.ready));
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // phase settings: reset value, minimum, ignored write, maximum, ignored
   // zero, upper use range, an ordinary value
   logic [TIMEOUT_W-1:0] phase_timeout [NUM_PHASES] =
      '{TIMEOUT_RESET, TIMEOUT_MIN, 20'd999, 20'hFFFFF, 20'd0, 20'd600000, 20'd1500};

   // reset, directed items, then random phases under several timeouts
   initial begin
      req_ch.valid    = 1'b0;
      req_ch.opcode   = OP_TICK;
      req_ch.position = POS_BETWEEN;
      req_ch.relay_ok = 1'b0;
      rsp_ch.ready    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.data     = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unused opcodes, commands from unknown, stop twice, relay failures,
      // position events while moving and while not, stop at either end
      queue_item(OP_BAD_LAST, POS_BOGUS, 1'b1);
      queue_item(OP_BAD_FIRST, POS_BETWEEN, 1'b0);
      queue_item(OP_BAD_FIRST + 3'd1, POS_CLOSED, 1'b1);
      queue_item(OP_OPEN, POS_BETWEEN, 1'b1);
      queue_item(OP_CLOSE, POS_BETWEEN, 1'b1);
      queue_item(OP_POS, POS_OPEN, 1'b0);
      queue_item(OP_STOP, POS_BETWEEN, 1'b0);
      queue_item(OP_STOP, POS_BOGUS, 1'b1);
      queue_item(OP_OPEN, POS_BETWEEN, 1'b0);
      queue_item(OP_OPEN, POS_BETWEEN, 1'b1);
      queue_item(OP_OPEN, POS_BETWEEN, 1'b1);
      queue_item(OP_STOP, POS_BETWEEN, 1'b1);
      queue_item(OP_CLOSE, POS_BETWEEN, 1'b1);
      queue_item(OP_POS, POS_BETWEEN, 1'b1);
      queue_item(OP_POS, POS_BOGUS, 1'b1);
      queue_item(OP_POS, POS_CLOSED, 1'b0);
      queue_item(OP_STOP, POS_CLOSED, 1'b1);
      queue_item(OP_CLOSE, POS_CLOSED, 1'b1);
      queue_item(OP_POS, POS_CLOSED, 1'b1);
      queue_item(OP_OPEN, POS_CLOSED, 1'b1);
      queue_item(OP_POS, POS_OPEN, 1'b1);
      queue_item(OP_STOP, POS_OPEN, 1'b0);
      queue_item(OP_CLOSE, POS_OPEN, 1'b0);
      queue_item(OP_CLOSE, POS_OPEN, 1'b1);
      queue_item(OP_POS, POS_OPEN, 1'b1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            write_timeout(phase_timeout[p]);
         end
         phase_items = 0;
         if (p == TIMEOUT_PHASE) begin
            queue_timeout_on_check();
         end
         queue_random_traffic(PHASE_ITEMS);
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("door_motion_controller_tb: PASS");
      end else begin
         $display("door_motion_controller_tb: FAIL");
      end
      $finish;
   end

endmodule
